>>> design/mrbr_pkg.sv
// Package for the block ring manager: sizes, action and status codes,
// register indexes, controller states and the controller-to-datapath command.
// No dependencies.
`timescale 1ns / 1ps

package mrbr_pkg;

  // Ring and reader sizes
  localparam int MaxSlots   = 128;
  localparam int SlotW      = $clog2(MaxSlots);
  localparam int SlotCntW   = $clog2(MaxSlots + 1);
  localparam int MaxReaders = 16;
  localparam int ReaderW    = $clog2(MaxReaders);
  localparam int Parts      = 16;
  localparam int PartW      = $clog2(Parts);
  localparam int PartCntW   = $clog2(Parts + 1);
  localparam int LastPart   = Parts - 1;

  // Field widths
  localparam int ActionW    = 3;
  localparam int StatusW    = 2;
  localparam int SeqW       = 32;
  localparam int BlockCntW  = 8;
  localparam int ReaderCntW = 5;
  localparam int PartMaskW  = 16;

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  typedef enum logic [ActionW-1:0] {
    ACT_PUT          = 3'd0,
    ACT_PUT_OR_DROP  = 3'd1,
    ACT_PUT_PART     = 3'd2,
    ACT_GET          = 3'd3,
    ACT_GET_PART     = 3'd4,
    ACT_RELEASE      = 3'd5,
    ACT_RELEASE_PART = 3'd6,
    ACT_SKIP         = 3'd7
  } action_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_DROPPED = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_COUNT  = 2'd0,
    CFG_READER_COUNT = 2'd1,
    CFG_PART_MASK    = 2'd2
  } cfg_index_e;

  typedef enum logic {
    CTL_IDLE = 1'b0,
    CTL_EXEC = 1'b1
  } ctl_state_e;

  // One pending mask per part of a slot
  typedef logic [Parts-1:0][MaxReaders-1:0] part_row_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // request transfer: latch item, read memories
    logic exec;     // update state and load the result register
  } dp_cmd_t;

endpackage

>>> design/mrbr_if.sv
// Handshake channels of the block ring manager: request and response.
// Depends on mrbr_pkg for field widths.
`timescale 1ns / 1ps

interface mrbr_req_if;
  logic                            valid;
  logic                            ready;
  logic [mrbr_pkg::ActionW-1:0]    action;
  logic [mrbr_pkg::ReaderW-1:0]    reader;

  modport source (output valid, action, reader, input ready);
  modport sink   (input valid, action, reader, output ready);
endinterface

interface mrbr_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [mrbr_pkg::StatusW-1:0]    status;
  logic [mrbr_pkg::SlotW-1:0]      block_index;
  logic [mrbr_pkg::PartW-1:0]      part_index;
  logic [mrbr_pkg::SeqW-1:0]       sequence_res;
  logic [mrbr_pkg::SeqW-1:0]       drops;

  modport source (output valid, status, block_index, part_index, sequence_res, drops,
                  input ready);
  modport sink   (input valid, status, block_index, part_index, sequence_res, drops,
                  output ready);
endinterface

>>> design/mrbr_ctrl.sv
// Controller of the block ring manager: request/response handshake and
// the two-state sequencer that drives the datapath. Depends on mrbr_pkg.
`timescale 1ns / 1ps

module mrbr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output mrbr_pkg::dp_cmd_t cmd_o
);

  mrbr_pkg::ctl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  // Result register can take a new result this cycle
  assign out_free = !out_valid_q || rsp_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mrbr_pkg::CTL_IDLE: begin
        if (req_valid_i) state_d = mrbr_pkg::CTL_EXEC;
      end
      mrbr_pkg::CTL_EXEC: begin
        if (out_free) state_d = mrbr_pkg::CTL_IDLE;
      end
      default: state_d = mrbr_pkg::CTL_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_ready_o   = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    unique case (state_q)
      mrbr_pkg::CTL_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
      end
      mrbr_pkg::CTL_EXEC: begin
        cmd_o.exec = out_free;
      end
      default: ;
    endcase
  end

  // Response valid: set by a finished item, cleared by a transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) out_valid_d = 1'b1;
    else if (rsp_ready_i) out_valid_d = 1'b0;
  end

  assign rsp_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mrbr_pkg::CTL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> design/mrbr_dp.sv
// Datapath of the block ring manager: configuration registers, ring
// pointers, counters, the pending-mask and sequence memories and the
// result register. Depends on mrbr_pkg.
`timescale 1ns / 1ps

module mrbr_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mrbr_pkg::dp_cmd_t                 cmd_i,
  input  logic [mrbr_pkg::ActionW-1:0]      req_action_i,
  input  logic [mrbr_pkg::ReaderW-1:0]      req_reader_i,
  input  logic                              cfg_we_i,
  input  logic [mrbr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [mrbr_pkg::CfgDataW-1:0]     cfg_data_i,
  output logic [mrbr_pkg::StatusW-1:0]      rsp_status_o,
  output logic [mrbr_pkg::SlotW-1:0]        rsp_block_index_o,
  output logic [mrbr_pkg::PartW-1:0]        rsp_part_index_o,
  output logic [mrbr_pkg::SeqW-1:0]         rsp_sequence_o,
  output logic [mrbr_pkg::SeqW-1:0]         rsp_drops_o
);

  localparam int Slots   = mrbr_pkg::MaxSlots;
  localparam int Readers = mrbr_pkg::MaxReaders;

  // Configuration registers
  logic [mrbr_pkg::BlockCntW-1:0]  block_count_q;
  logic [mrbr_pkg::ReaderCntW-1:0] reader_count_q;
  logic [mrbr_pkg::PartMaskW-1:0]  part_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q  <= mrbr_pkg::BlockCntW'(Slots);
      reader_count_q <= mrbr_pkg::ReaderCntW'(1);
      part_mask_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mrbr_pkg::CFG_BLOCK_COUNT:  block_count_q  <= cfg_data_i[mrbr_pkg::BlockCntW-1:0];
        mrbr_pkg::CFG_READER_COUNT: reader_count_q <= cfg_data_i[mrbr_pkg::ReaderCntW-1:0];
        mrbr_pkg::CFG_PART_MASK:    part_mask_q    <= cfg_data_i[mrbr_pkg::PartMaskW-1:0];
        default: ;
      endcase
    end
  end

  // Ring state
  logic [mrbr_pkg::SlotW-1:0]    write_slot_q, write_slot_d;
  logic [mrbr_pkg::PartW-1:0]    write_part_q, write_part_d;
  logic [mrbr_pkg::SlotW-1:0]    read_slot_q [Readers];
  logic [mrbr_pkg::PartCntW-1:0] read_part_q [Readers];
  logic [mrbr_pkg::SeqW-1:0]     put_total_q, put_total_d;
  logic [mrbr_pkg::SeqW-1:0]     drop_total_q, drop_total_d;

  // Latched item and slot address
  mrbr_pkg::action_e            action_q;
  logic [mrbr_pkg::ReaderW-1:0] reader_q;
  logic [mrbr_pkg::SlotW-1:0]   addr_q, addr_d;

  // Memories, read on capture, written on exec
  logic [Readers-1:0]        pend_mem [Slots];
  mrbr_pkg::part_row_t       part_mem [Slots];
  logic [mrbr_pkg::SeqW-1:0] seq_mem  [Slots];
  logic [Slots-1:0]          pend_vld_q, part_vld_q;
  logic [Readers-1:0]        pend_rd_q;
  mrbr_pkg::part_row_t       part_rd_q;
  logic [mrbr_pkg::SeqW-1:0] seq_rd_q;

  // Slot address of the incoming item
  always_comb begin
    case (mrbr_pkg::action_e'(req_action_i)) inside
      mrbr_pkg::ACT_PUT, mrbr_pkg::ACT_PUT_OR_DROP, mrbr_pkg::ACT_PUT_PART:
        addr_d = write_slot_q;
      default:
        addr_d = read_slot_q[req_reader_i];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= mrbr_pkg::action_e'(req_action_i);
      reader_q <= req_reader_i;
      addr_q   <= addr_d;
    end
  end

  // Ring size with out-of-range counts saturated
  logic [mrbr_pkg::SlotCntW-1:0] ring_size;
  logic [mrbr_pkg::SlotCntW-1:0] slot_inc;
  logic [mrbr_pkg::SlotW-1:0]    next_slot;

  always_comb begin
    if (block_count_q == '0) ring_size = mrbr_pkg::SlotCntW'(1);
    else if (mrbr_pkg::SlotCntW'(block_count_q) > mrbr_pkg::SlotCntW'(Slots))
      ring_size = mrbr_pkg::SlotCntW'(Slots);
    else ring_size = mrbr_pkg::SlotCntW'(block_count_q);
  end

  assign slot_inc  = mrbr_pkg::SlotCntW'(addr_q) + 1'b1;
  assign next_slot = (slot_inc >= ring_size) ? '0 : slot_inc[mrbr_pkg::SlotW-1:0];

  // Full-block reader mask from the saturated reader count
  logic [mrbr_pkg::ReaderCntW-1:0] rc_sat;
  logic [Readers:0]                rc_one, rc_mask_wide;
  logic [Readers-1:0]              reader_mask;

  assign rc_sat = (reader_count_q > mrbr_pkg::ReaderCntW'(Readers))
                  ? mrbr_pkg::ReaderCntW'(Readers) : reader_count_q;
  assign rc_one       = (Readers + 1)'(1) << rc_sat;
  assign rc_mask_wide = rc_one - 1'b1;
  assign reader_mask  = rc_mask_wide[Readers-1:0];

  // Current contents; a pending-mask entry never written since reset reads as zero
  logic [Readers-1:0]            pend_cur, rbit;
  mrbr_pkg::part_row_t           row_cur;
  logic [mrbr_pkg::PartCntW-1:0] rd_part;

  assign pend_cur = pend_vld_q[addr_q] ? pend_rd_q : '0;
  assign row_cur  = part_vld_q[addr_q] ? part_rd_q : '0;
  assign rbit     = Readers'(1) << reader_q;
  assign rd_part  = read_part_q[reader_q];

  // Step: memory writes, pointer updates, result
  logic                          pend_we, part_we, seq_we, rs_we, rp_we;
  logic [Readers-1:0]            pend_wd;
  mrbr_pkg::part_row_t           part_wd;
  logic [mrbr_pkg::SlotW-1:0]    rs_wd;
  logic [mrbr_pkg::PartCntW-1:0] rp_wd;
  mrbr_pkg::status_e             res_status;
  logic [mrbr_pkg::PartW-1:0]    res_part;
  logic [mrbr_pkg::SeqW-1:0]     res_seq;

  always_comb begin
    pend_we      = 1'b0;
    pend_wd      = pend_cur;
    part_we      = 1'b0;
    part_wd      = row_cur;
    seq_we       = 1'b0;
    rs_we        = 1'b0;
    rs_wd        = next_slot;
    rp_we        = 1'b0;
    rp_wd        = '0;
    write_slot_d = write_slot_q;
    write_part_d = write_part_q;
    put_total_d  = put_total_q;
    drop_total_d = drop_total_q;
    res_status   = mrbr_pkg::STAT_OK;
    res_part     = '0;
    res_seq      = '0;

    case (action_q) inside
      mrbr_pkg::ACT_PUT, mrbr_pkg::ACT_PUT_OR_DROP: begin
        if (pend_cur != '0) begin
          if (action_q == mrbr_pkg::ACT_PUT_OR_DROP) begin
            res_status   = mrbr_pkg::STAT_DROPPED;
            res_seq      = put_total_q;
            drop_total_d = drop_total_q + 1'b1;
            put_total_d  = put_total_q + 1'b1;
          end else begin
            res_status = mrbr_pkg::STAT_FULL;
          end
        end else begin
          res_seq      = put_total_q;
          seq_we       = 1'b1;
          pend_we      = 1'b1;
          pend_wd      = reader_mask;
          write_slot_d = next_slot;
          put_total_d  = put_total_q + 1'b1;
        end
      end
      mrbr_pkg::ACT_PUT_PART: begin
        if (pend_cur != '0) begin
          res_status = mrbr_pkg::STAT_FULL;
        end else begin
          res_part              = write_part_q;
          res_seq               = put_total_q;
          seq_we                = (write_part_q == '0);
          part_we               = 1'b1;
          part_wd[write_part_q] = part_mask_q[Readers-1:0];
          // last part completes the block
          if (write_part_q == mrbr_pkg::PartW'(mrbr_pkg::LastPart)) begin
            pend_we      = 1'b1;
            pend_wd      = reader_mask;
            write_slot_d = next_slot;
            put_total_d  = put_total_q + 1'b1;
          end
          write_part_d = write_part_q + 1'b1;
        end
      end
      mrbr_pkg::ACT_GET: begin
        if ((pend_cur & rbit) != '0) res_seq = seq_rd_q;
        else res_status = mrbr_pkg::STAT_EMPTY;
      end
      mrbr_pkg::ACT_GET_PART: begin
        // a part counter past the last part reads as empty
        if (!rd_part[mrbr_pkg::PartW] &&
            ((row_cur[rd_part[mrbr_pkg::PartW-1:0]] & rbit) != '0)) begin
          res_part = rd_part[mrbr_pkg::PartW-1:0];
          res_seq  = seq_rd_q;
          rp_we    = 1'b1;
          rp_wd    = rd_part + 1'b1;
        end else begin
          res_status = mrbr_pkg::STAT_EMPTY;
        end
      end
      mrbr_pkg::ACT_RELEASE, mrbr_pkg::ACT_RELEASE_PART: begin
        pend_we = 1'b1;
        pend_wd = pend_cur & ~rbit;
        rs_we   = 1'b1;
        if (action_q == mrbr_pkg::ACT_RELEASE_PART) begin
          part_we = 1'b1;
          for (int i = 0; i < mrbr_pkg::Parts; i++) begin
            part_wd[i] = row_cur[i] & ~rbit;
          end
          rp_we = 1'b1;
          rp_wd = '0;
        end
      end
      default: begin  // skip
        if ((pend_cur & rbit) != '0) begin
          pend_we = 1'b1;
          pend_wd = pend_cur & ~rbit;
          rs_we   = 1'b1;
        end else begin
          res_status = mrbr_pkg::STAT_EMPTY;
        end
      end
    endcase
  end

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pend_rd_q <= pend_mem[addr_d];
      part_rd_q <= part_mem[addr_d];
      seq_rd_q  <= seq_mem[addr_d];
    end
    if (cmd_i.exec && pend_we) pend_mem[addr_q] <= pend_wd;
    if (cmd_i.exec && part_we) part_mem[addr_q] <= part_wd;
    if (cmd_i.exec && seq_we)  seq_mem[addr_q]  <= put_total_q;
  end

  // Entry valid bits for the pending masks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= '0;
      part_vld_q <= '0;
    end else if (cmd_i.exec) begin
      if (pend_we) pend_vld_q[addr_q] <= 1'b1;
      if (part_we) part_vld_q[addr_q] <= 1'b1;
    end
  end

  // Pointers and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_slot_q <= '0;
      write_part_q <= '0;
      put_total_q  <= '0;
      drop_total_q <= '0;
      for (int i = 0; i < Readers; i++) begin
        read_slot_q[i] <= '0;
        read_part_q[i] <= '0;
      end
    end else if (cmd_i.exec) begin
      write_slot_q <= write_slot_d;
      write_part_q <= write_part_d;
      put_total_q  <= put_total_d;
      drop_total_q <= drop_total_d;
      if (rs_we) read_slot_q[reader_q] <= rs_wd;
      if (rp_we) read_part_q[reader_q] <= rp_wd;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rsp_status_o      <= res_status;
      rsp_block_index_o <= addr_q;
      rsp_part_index_o  <= res_part;
      rsp_sequence_o    <= res_seq;
      rsp_drops_o       <= drop_total_d;
    end
  end

endmodule

>>> design/multi_reader_block_ring_manager.sv
// Block ring manager: one writer, up to sixteen readers, whole-block and part descriptors.
// A request is latched with its slot memory read, then executed into the result register once
// that register is free; one request is in work at a time, the registered read of the
// slot memories followed by their read-modify-write; a stalled response holds the next one.
// Reset: asynchronous, clears pointers, counters and all pending-mask valid bits at once.
// Depends on mrbr_pkg, mrbr_if, mrbr_ctrl and mrbr_dp.
`timescale 1ns / 1ps

module multi_reader_block_ring_manager (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mrbr_req_if.sink                      req,
  mrbr_rsp_if.source                    rsp,
  input  logic                          cfg_we_i,
  input  logic [mrbr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mrbr_pkg::CfgDataW-1:0] cfg_data_i
);

  mrbr_pkg::dp_cmd_t cmd;

  // Sequencer
  mrbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .cmd_o       (cmd)
  );

  // State and result
  mrbr_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .req_action_i      (req.action),
    .req_reader_i      (req.reader),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .rsp_status_o      (rsp.status),
    .rsp_block_index_o (rsp.block_index),
    .rsp_part_index_o  (rsp.part_index),
    .rsp_sequence_o    (rsp.sequence_res),
    .rsp_drops_o       (rsp.drops)
  );

endmodule

>>> design/mrbr_checker.sv
// Port-level checks for the block ring manager and their bind to the top level.
// Depends on mrbr_pkg.
`timescale 1ns / 1ps

module mrbr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [mrbr_pkg::StatusW-1:0]  rsp_status_i,
  input logic [mrbr_pkg::PartW-1:0]    rsp_part_index_i,
  input logic [mrbr_pkg::SeqW-1:0]     rsp_sequence_i
);

  // A held response stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  // A held response keeps its sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_sequence_i))
    else $error("response sequence changed while stalled");

  // One item at a time: no request taken right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while the previous one is in work");

  // Full and empty answers carry no sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == mrbr_pkg::STAT_FULL ||
                    rsp_status_i == mrbr_pkg::STAT_EMPTY) |-> rsp_sequence_i == '0)
    else $error("sequence on a full or empty answer");

  // A dropped put is never a part put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == mrbr_pkg::STAT_DROPPED |-> rsp_part_index_i == '0)
    else $error("part index on a dropped put");

endmodule

bind multi_reader_block_ring_manager mrbr_checker u_mrbr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req.valid),
  .req_ready_i      (req.ready),
  .rsp_valid_i      (rsp.valid),
  .rsp_ready_i      (rsp.ready),
  .rsp_status_i     (rsp.status),
  .rsp_part_index_i (rsp.part_index),
  .rsp_sequence_i   (rsp.sequence_res)
);

>>> dv/tb_multi_reader_block_ring_manager.sv
// Testbench for the block ring manager: directed requests, then eight random phases over
// several ring settings, checked against a scoreboard that predicts every response.
// Depends on mrbr_pkg, mrbr_if and multi_reader_block_ring_manager.
`timescale 1ns / 1ps

module tb_multi_reader_block_ring_manager;
  import mrbr_pkg::*;

  localparam int                 CycleLimit  = 200000;
  localparam int                 RandomItems = 155;
  localparam int                 PhaseCount  = 8;
  // Index past the last register: the block ignores a write to it
  localparam logic [CfgIdxW-1:0] CfgSpareIdx = 2'd3;

  // One response as the block reports it
  typedef struct packed {
    status_e            status;
    logic [SlotW-1:0]   slot;
    logic [PartW-1:0]   part;
    logic [SeqW-1:0]    seq;
    logic [SeqW-1:0]    drops;
  } ring_result_t;

  // Ring state copy and the queue of responses still to come
  class ring_scoreboard;
    logic [BlockCntW-1:0]  block_count;
    logic [ReaderCntW-1:0] reader_count;
    logic [PartMaskW-1:0]  part_mask;
    int                    wr_slot;
    int                    wr_part;
    int                    rd_slot [MaxReaders];
    int                    rd_part [MaxReaders];
    logic [MaxReaders-1:0] slot_pend [MaxSlots];
    logic [MaxReaders-1:0] part_pend [MaxSlots*Parts];
    logic [SeqW-1:0]       slot_seq [MaxSlots];
    logic [SeqW-1:0]       put_total;
    logic [SeqW-1:0]       drop_total;
    ring_result_t          expected_q [$];
    int                    errors;

    function new();
      block_count  = 8'd128;
      reader_count = 5'd1;
      part_mask    = '0;
      wr_slot      = 0;
      wr_part      = 0;
      foreach (rd_slot[i]) begin
        rd_slot[i] = 0;
        rd_part[i] = 0;
      end
      foreach (slot_pend[i]) begin
        slot_pend[i] = '0;
        slot_seq[i]  = '0;
      end
      foreach (part_pend[i]) part_pend[i] = '0;
      put_total  = '0;
      drop_total = '0;
      errors     = 0;
    endfunction

    function void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CFG_BLOCK_COUNT) block_count = data[BlockCntW-1:0];
      else if (idx == CFG_READER_COUNT) reader_count = data[ReaderCntW-1:0];
      else if (idx == CFG_PART_MASK) part_mask = data[PartMaskW-1:0];
    endfunction

    // Zero acts as one slot, anything above the ring maximum as the maximum
    function int ring_size();
      if (block_count == 0) return 1;
      if (block_count > MaxSlots) return MaxSlots;
      return block_count;
    endfunction

    function int active_readers();
      return (reader_count > MaxReaders) ? MaxReaders : reader_count;
    endfunction

    function logic [MaxReaders-1:0] reader_mask();
      logic [MaxReaders:0] m;
      m = (17'd1 << active_readers()) - 17'd1;
      return m[MaxReaders-1:0];
    endfunction

    // A pointer left past a shrunk ring wraps to zero on its next advance
    function int next_slot(int s);
      return (s + 1 >= ring_size()) ? 0 : s + 1;
    endfunction

    // Update the ring for one accepted request and queue its response
    function void note_request(action_e act, logic [ReaderW-1:0] r);
      ring_result_t e;
      int           s;
      int           p;
      e.status = STAT_OK;
      e.slot   = '0;
      e.part   = '0;
      e.seq    = '0;
      case (act) inside
        ACT_PUT, ACT_PUT_OR_DROP, ACT_PUT_PART: begin
          s      = wr_slot;
          e.slot = SlotW'(s);
          if (slot_pend[s] != '0) begin
            if (act == ACT_PUT_OR_DROP) begin
              e.status   = STAT_DROPPED;
              e.seq      = put_total;
              drop_total = drop_total + 1;
              put_total  = put_total + 1;
            end else begin
              e.status = STAT_FULL;
            end
          end else if (act != ACT_PUT_PART) begin
            e.seq        = put_total;
            slot_seq[s]  = put_total;
            slot_pend[s] = reader_mask();
            wr_slot      = next_slot(s);
            put_total    = put_total + 1;
          end else begin
            p      = wr_part;
            e.part = PartW'(p);
            e.seq  = put_total;
            if (p == 0) slot_seq[s] = put_total;
            part_pend[s*Parts+p] = part_mask;
            // last part publishes the whole block
            if (p == LastPart) begin
              slot_pend[s] = reader_mask();
              wr_slot      = next_slot(s);
              put_total    = put_total + 1;
            end
            wr_part = (p + 1) % Parts;
          end
        end
        default: begin
          s      = rd_slot[r];
          e.slot = SlotW'(s);
          case (act) inside
            ACT_GET: begin
              if (slot_pend[s][r]) e.seq = slot_seq[s];
              else e.status = STAT_EMPTY;
            end
            ACT_GET_PART: begin
              p = rd_part[r];
              // a part counter past the last part stays empty until release_part
              if (p < Parts && part_pend[s*Parts+p][r]) begin
                e.part     = PartW'(p);
                e.seq      = slot_seq[s];
                rd_part[r] = p + 1;
              end else begin
                e.status = STAT_EMPTY;
              end
            end
            ACT_RELEASE, ACT_RELEASE_PART: begin
              slot_pend[s][r] = 1'b0;
              if (act == ACT_RELEASE_PART) begin
                for (int i = 0; i < Parts; i++) part_pend[s*Parts+i][r] = 1'b0;
                rd_part[r] = 0;
              end
              rd_slot[r] = next_slot(s);
            end
            default: begin
              if (slot_pend[s][r]) begin
                slot_pend[s][r] = 1'b0;
                rd_slot[r]      = next_slot(s);
              end else begin
                e.status = STAT_EMPTY;
              end
            end
          endcase
        end
      endcase
      e.drops = drop_total;
      expected_q.push_back(e);
    endfunction

    function void compare_field(string name, logic [SeqW-1:0] want, logic [SeqW-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: response with nothing expected: expected none, actual %0h",
                 $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", SeqW'(want.status), SeqW'(got.status));
      compare_field("block_index", SeqW'(want.slot), SeqW'(got.slot));
      compare_field("part_index", SeqW'(want.part), SeqW'(got.part));
      compare_field("sequence_res", want.seq, got.seq);
      compare_field("drops", want.drops, got.drops);
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int                  send_idle_pct;
  int                  recv_stall_pct;
  int                  cycles;
  ring_result_t        rsp_seen;
  ring_scoreboard      sb;

  // Ring settings and idle profile of each random phase
  logic [BlockCntW-1:0]  phase_bc [PhaseCount] = '{8'd8, 8'd1, 8'd0, 8'd255,
                                                   8'd3, 8'd128, 8'd5, 8'd2};
  logic [ReaderCntW-1:0] phase_rc [PhaseCount] = '{5'd4, 5'd16, 5'd2, 5'd31,
                                                   5'd0, 5'd16, 5'd7, 5'd1};
  logic [PartMaskW-1:0]  phase_pm [PhaseCount] = '{16'h000F, 16'hFFFF, 16'h0001, 16'hA5A5,
                                                   16'hFFFF, 16'h5A5A, 16'h0000, 16'h8001};
  int          idle_send  [4] = '{0, 64, 0, 31};
  int          idle_recv  [4] = '{0, 0, 64, 31};

  mrbr_req_if req_ch ();
  mrbr_rsp_if rsp_ch ();

  multi_reader_block_ring_manager dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #6 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Response side: check each transfer, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      rsp_seen.status = status_e'(rsp_ch.status);
      rsp_seen.slot   = rsp_ch.block_index;
      rsp_seen.part   = rsp_ch.part_index;
      rsp_seen.seq    = rsp_ch.sequence_res;
      rsp_seen.drops  = rsp_ch.drops;
      sb.check_result(rsp_seen);
    end
    rsp_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Offer one request, idling first at random; returns at its transfer edge
  task automatic send_request(action_e act, logic [ReaderW-1:0] r);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      req_ch.valid  <= 1'b0;
      req_ch.action <= ActionW'($urandom);
      req_ch.reader <= ReaderW'($urandom);
      @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.reader <= r;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(act, r);
  endtask

  // Drop valid and let every response come back
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.apply_reg(idx, data);
    @(posedge clk);
  endtask

  // Unused high data bits carry noise; the block keeps only the register width
  task automatic program_ring(logic [BlockCntW-1:0] bc, logic [ReaderCntW-1:0] rc,
                              logic [PartMaskW-1:0] pm);
    logic [CfgDataW-1:0] filler;
    filler = CfgDataW'($urandom);
    write_reg(CFG_BLOCK_COUNT, {filler[CfgDataW-1:BlockCntW], bc});
    filler = CfgDataW'($urandom);
    write_reg(CFG_READER_COUNT, {filler[CfgDataW-1:ReaderCntW], rc});
    write_reg(CFG_PART_MASK, pm);
    write_reg(CfgSpareIdx, CfgDataW'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Mostly a writer filling the ring and readers draining it, a quarter noise.
  // A whole-block put never lands inside a part sequence, so every sequence
  // a reader can see has been stored.
  function automatic void pick_request(output action_e act, output logic [ReaderW-1:0] r);
    int rc_eff;
    int s;
    int p;
    int roll;
    bit writer_move;
    rc_eff      = sb.active_readers();
    roll        = $urandom_range(99, 0);
    act         = action_e'($urandom_range(7, 0));
    r           = ReaderW'($urandom_range(MaxReaders - 1, 0));
    writer_move = 1'b0;
    if (roll >= 25) begin
      writer_move = 1'b1;
      if (rc_eff > 0 && roll >= 62) begin
        r           = ReaderW'($urandom_range(rc_eff - 1, 0));
        s           = sb.rd_slot[r];
        p           = sb.rd_part[r];
        writer_move = 1'b0;
        if (p < Parts && sb.part_pend[s*Parts+p][r] && $urandom_range(9, 0) != 0) begin
          act = ACT_GET_PART;
        end else if (sb.slot_pend[s][r]) begin
          case ($urandom_range(4, 0))
            0:       act = ACT_GET;
            1:       act = ACT_GET_PART;
            2:       act = ACT_RELEASE;
            3:       act = ACT_RELEASE_PART;
            default: act = ACT_SKIP;
          endcase
        end else if (p >= Parts) begin
          act = $urandom_range(1, 0) ? ACT_RELEASE_PART : ACT_GET_PART;
        end else begin
          writer_move = 1'b1;
        end
      end
    end
    if (writer_move) begin
      // a full ring: let some reader move on
      if (sb.slot_pend[sb.wr_slot] != '0 && rc_eff > 0 && $urandom_range(1, 0)) begin
        act = ACT_RELEASE;
        r   = ReaderW'($urandom_range(rc_eff - 1, 0));
      end else if (sb.wr_part != 0) begin
        act = ACT_PUT_PART;
      end else begin
        case ($urandom_range(9, 0))
          0, 1, 2, 3: act = ACT_PUT;
          4, 5, 6:    act = ACT_PUT_OR_DROP;
          default:    act = ACT_PUT_PART;
        endcase
      end
    end
    if (sb.wr_part != 0 && (act == ACT_PUT || act == ACT_PUT_OR_DROP)) act = ACT_PUT_PART;
  endfunction

  // Empty ring, first puts, reads and releases, then a one-slot ring that fills,
  // drops, reports full and starts a part sequence
  task automatic directed_requests();
    send_request(ACT_GET, 4'd0);
    send_request(ACT_GET_PART, 4'd15);
    send_request(ACT_SKIP, 4'd0);
    send_request(ACT_PUT, 4'd0);
    send_request(ACT_PUT_OR_DROP, 4'd0);
    send_request(ACT_GET, 4'd0);
    send_request(ACT_SKIP, 4'd0);
    send_request(ACT_RELEASE, 4'd0);
    send_request(ACT_RELEASE_PART, 4'd15);
    wait_idle();
    // write pointer is now past the shrunk ring
    program_ring(8'd1, 5'd2, 16'hFFFF);
    send_request(ACT_PUT, 4'd0);
    send_request(ACT_PUT, 4'd0);
    send_request(ACT_PUT, 4'd0);
    send_request(ACT_PUT_OR_DROP, 4'd0);
    send_request(ACT_PUT_PART, 4'd0);
    send_request(ACT_GET, 4'd1);
    send_request(ACT_RELEASE_PART, 4'd0);
    send_request(ACT_RELEASE, 4'd0);
    send_request(ACT_RELEASE, 4'd1);
    send_request(ACT_PUT_PART, 4'd0);
    send_request(ACT_GET_PART, 4'd0);
    send_request(ACT_GET_PART, 4'd0);
    send_request(ACT_GET, 4'd0);
    wait_idle();
  endtask

  initial begin
    action_e            act;
    logic [ReaderW-1:0] r;
    clk            = 1'b0;
    rst_n          = 1'b0;
    cycles         = 0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    req_ch.valid   = 1'b0;
    req_ch.action  = '0;
    req_ch.reader  = '0;
    rsp_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sb             = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_requests();
    for (int ph = 0; ph < PhaseCount; ph++) begin
      program_ring(phase_bc[ph], phase_rc[ph], phase_pm[ph]);
      send_idle_pct  = idle_send[ph % 4];
      recv_stall_pct <= idle_recv[ph % 4];
      repeat (RandomItems) begin
        pick_request(act, r);
        send_request(act, r);
      end
      wait_idle();
    end
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
